// File: rtl/ycbcr422_to_bgrx_converter_unit_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef YCBCR422_TO_BGRX_CONVERTER_UNIT_DEFINES_SVH
`define YCBCR422_TO_BGRX_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define YCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/ycc2bgr_pkg.sv
// Constants, types and conversion function for the YCbCr 4:2:2 to BGR converter.
package ycc2bgr_pkg;

    localparam int LINE_MAX = 4096;
    localparam int COL_W    = $clog2(LINE_MAX);
    localparam int WIDTH_W  = 13;
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 28;
    localparam int FRAC_W   = 16;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef enum logic [0:0] {
        REG_LINE_WIDTH = 1'b0
    } t_reg_idx;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = WIDTH_W'(640);

    localparam logic signed [SUM_W-1:0] K_LUMA     = SUM_W'(76284);
    localparam logic signed [SUM_W-1:0] K_CR_RED   = SUM_W'(104595);
    localparam logic signed [SUM_W-1:0] K_CR_GREEN = SUM_W'(53281);
    localparam logic signed [SUM_W-1:0] K_CB_GREEN = SUM_W'(25690);
    localparam logic signed [SUM_W-1:0] K_CB_BLUE  = SUM_W'(132186);

    localparam logic signed [PIX_W:0] LUMA_OFS   = (PIX_W+1)'(16);
    localparam logic signed [PIX_W:0] CHROMA_OFS = (PIX_W+1)'(128);

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_pixel;

    function automatic logic [PIX_W-1:0] clip_q16(input logic signed [SUM_W-1:0] sum);
        logic [SUM_W-FRAC_W-1:0] v;
        logic [PIX_W-1:0]        res;
        v = sum[SUM_W-1:FRAC_W];
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (v > (SUM_W-FRAC_W)'(255)) begin
            res = '1;
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

    function automatic t_pixel convert_pixel(input logic [PIX_W-1:0] luma,
                                             input logic [PIX_W-1:0] cb,
                                             input logic [PIX_W-1:0] cr);
        logic signed [PIX_W:0]   y9;
        logic signed [PIX_W:0]   cb9;
        logic signed [PIX_W:0]   cr9;
        logic signed [SUM_W-1:0] base;
        t_pixel                  px;
        y9   = $signed({1'b0, luma}) - LUMA_OFS;
        cb9  = $signed({1'b0, cb}) - CHROMA_OFS;
        cr9  = $signed({1'b0, cr}) - CHROMA_OFS;
        base = K_LUMA * SUM_W'(y9);
        px.blue  = clip_q16(base + K_CB_BLUE * SUM_W'(cb9));
        px.green = clip_q16(base - K_CR_GREEN * SUM_W'(cr9) - K_CB_GREEN * SUM_W'(cb9));
        px.red   = clip_q16(base + K_CR_RED * SUM_W'(cr9));
        return px;
    endfunction

endpackage

// File: rtl/ycbcr422_to_bgrx_converter_unit.sv
// Top level: YCbCr 4:2:2 macropixel to BGR pixel stream converter (BT.601 video range).
//
// Each input item is one macropixel (Y1, Cb, Y2, Cr) and yields one or two BGR
// pixels on the output channel, one pixel per cycle while i_out_ready does not
// stall the output register. An item stays in the input register until its last
// pixel is sent; it yields one pixel when its second pixel falls past the line
// width. Each pixel is converted combinationally from the input register and
// registered in the output register. The next item is taken in the cycle the
// last pixel of the current one moves to the output register. line_width (APB
// offset 0, reset 640) is clamped to 1..4096; o_last_of_pair marks the final
// pixel of an item and o_line_end the last pixel of a line.
`include "ycbcr422_to_bgrx_converter_unit_defines.svh"

module ycbcr422_to_bgrx_converter_unit
    import ycc2bgr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PIX_W-1:0]   i_luma_first,
    input  logic [PIX_W-1:0]   i_chroma_blue,
    input  logic [PIX_W-1:0]   i_luma_second,
    input  logic [PIX_W-1:0]   i_chroma_red,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PIX_W-1:0]   o_blue_out,
    output logic [PIX_W-1:0]   o_green_out,
    output logic [PIX_W-1:0]   o_red_out,
    output logic               o_last_of_pair,
    output logic               o_line_end
);

    logic [WIDTH_W-1:0] r_line_width;
    logic [COL_W-1:0]   r_col, n_col;

    logic               r_in_valid;
    logic               r_phase;
    logic               r_second;
    logic               r_le1;
    logic               r_le2;
    logic [PIX_W-1:0]   r_y1, r_y2, r_cb, r_cr;

    logic               r_out_valid;
    t_pixel             r_pix;
    logic               r_last;
    logic               r_le;

    logic               cfg_wr;
    logic [WIDTH_W-1:0] w_eff;
    logic               n_second;
    logic               n_le2;
    logic [COL_W+1:0]   col_plus2;
    logic               in_acc;
    logic               load_out;
    logic               in_done;
    logic [PIX_W-1:0]   sel_luma;
    t_pixel             n_pix;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_LINE_WIDTH);
    assign prdata = (paddr[PADDR_W-1] == REG_LINE_WIDTH) ?
                    PDATA_W'(r_line_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
        end else if (cfg_wr) begin
            r_line_width <= pwdata[WIDTH_W-1:0];
        end
    end

    // Line position
    always_comb begin
        if (r_line_width == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (r_line_width > WIDTH_W'(LINE_MAX)) begin
            w_eff = WIDTH_W'(LINE_MAX);
        end else begin
            w_eff = r_line_width;
        end
        col_plus2 = (COL_W+2)'(r_col) + (COL_W+2)'(2);
        n_second  = ((WIDTH_W)'(r_col) + WIDTH_W'(1)) < w_eff;
        n_le2     = col_plus2 >= (COL_W+2)'(w_eff);
        n_col     = n_le2 ? '0 : col_plus2[COL_W-1:0];
    end

    // Handshake
    assign load_out   = r_in_valid && (!r_out_valid || i_out_ready);
    assign in_done    = load_out && (r_phase || !r_second);
    assign o_in_ready = !r_in_valid || in_done;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_in_valid <= 1'b0;
            r_phase    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col      <= n_col;
                r_in_valid <= 1'b1;
                r_phase    <= 1'b0;
            end else if (in_done) begin
                r_in_valid <= 1'b0;
                r_phase    <= 1'b0;
            end else if (load_out) begin
                r_phase    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_y1     <= i_luma_first;
            r_y2     <= i_luma_second;
            r_cb     <= i_chroma_blue;
            r_cr     <= i_chroma_red;
            r_second <= n_second;
            r_le1    <= !n_second;
            r_le2    <= n_le2;
        end
    end

    // Conversion
    assign sel_luma = r_phase ? r_y2 : r_y1;
    assign n_pix    = convert_pixel(sel_luma, r_cb, r_cr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_pix  <= n_pix;
            r_last <= r_phase || !r_second;
            r_le   <= r_phase ? r_le2 : r_le1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_blue_out     = r_pix.blue;
    assign o_green_out    = r_pix.green;
    assign o_red_out      = r_pix.red;
    assign o_last_of_pair = r_last;
    assign o_line_end     = r_le;

    `YCC_ASSERT_IMPL(a_phase_needs_second, i_clk, i_rst_n, r_in_valid && r_phase, r_second)
    `YCC_ASSERT_IMPL(a_mid_pair_not_line_end, i_clk, i_rst_n, r_out_valid && !r_last, !r_le)
    `YCC_ASSERT_NEXT(a_accept_loads_first, i_clk, i_rst_n, in_acc, r_in_valid && !r_phase)
    `YCC_ASSERT_NEXT(a_first_pixel_follows, i_clk, i_rst_n, in_acc, r_out_valid || load_out || r_in_valid)

endmodule
